@@ design/utf8s_pkg.sv @@
// types, constants and code point test for the utf8 invisible character stripper
`default_nettype none
package utf8s_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] pend_cnt;
    logic [2:0] exp_len;
    logic       at_start;
    logic       pend_from_start;
  } ctl_t;

  typedef logic [2:0][7:0] pend_t;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
  } burst_t;

  localparam logic [2:0] SEQ_LEN_INVALID = 3'd0;
  localparam logic [2:0] SEQ_LEN_ONE     = 3'd1;
  localparam logic [2:0] SEQ_LEN_TWO     = 3'd2;
  localparam logic [2:0] SEQ_LEN_THREE   = 3'd3;
  localparam logic [2:0] SEQ_LEN_FOUR    = 3'd4;

  localparam logic [20:0] CP_BOM      = 21'h00FEFF;
  localparam logic [20:0] CP_ZW_LO    = 21'h00200B;
  localparam logic [20:0] CP_ZW_HI    = 21'h00200F;
  localparam logic [20:0] CP_BIDI_LO  = 21'h00202A;
  localparam logic [20:0] CP_BIDI_HI  = 21'h00202E;
  localparam logic [20:0] CP_WJ       = 21'h002060;
  localparam logic [20:0] CP_ISO_LO   = 21'h002066;
  localparam logic [20:0] CP_ISO_HI   = 21'h002069;
  localparam logic [20:0] CP_SHY      = 21'h0000AD;
  localparam logic [20:0] CP_VS_LO    = 21'h00FE00;
  localparam logic [20:0] CP_VS_HI    = 21'h00FE0F;

  function automatic logic invisible_cp(input logic [20:0] cp);
    return cp inside {[CP_ZW_LO:CP_ZW_HI], [CP_BIDI_LO:CP_BIDI_HI], CP_WJ,
                      [CP_ISO_LO:CP_ISO_HI], CP_BOM, CP_SHY, [CP_VS_LO:CP_VS_HI]};
  endfunction

  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) len = SEQ_LEN_ONE;
    else if (b[7:5] == 3'b110) len = SEQ_LEN_TWO;
    else if (b[7:4] == 4'b1110) len = SEQ_LEN_THREE;
    else if (b[7:3] == 5'b11110) len = SEQ_LEN_FOUR;
    else len = SEQ_LEN_INVALID;
    return len;
  endfunction

endpackage
`default_nettype wire

@@ design/utf8s_step.sv @@
// per-byte decode step: next sequence state and the bytes to emit
`default_nettype none
module utf8s_step
  import utf8s_pkg::*;
(
  input  wire in_item_t item,
  input  wire ctl_t     ctl,
  input  wire pend_t    pend,
  output ctl_t          ctl_nxt,
  output pend_t         pend_nxt,
  output burst_t        burst
);

  logic [7:0]  b;
  logic        cont;
  logic        complete;
  logic        keep;
  logic        fresh;
  logic [1:0]  flush_cnt;
  logic        emit_b;
  logic [2:0]  len;
  logic [20:0] cp;

  always_comb begin
    b         = item.in_byte;
    cont      = (b[7:6] == 2'b10);
    ctl_nxt   = ctl;
    pend_nxt  = pend;
    flush_cnt = 2'd0;
    emit_b    = 1'b0;
    fresh     = 1'b1;
    len       = seq_length(b);

    case (ctl.exp_len)
      SEQ_LEN_TWO:   cp = {10'd0, pend[0][4:0], b[5:0]};
      SEQ_LEN_THREE: cp = {5'd0, pend[0][3:0], pend[1][5:0], b[5:0]};
      default:       cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], b[5:0]};
    endcase
    complete = (({1'b0, ctl.pend_cnt} + 3'd1) >= ctl.exp_len);
    keep     = !invisible_cp(cp) || ((cp == CP_BOM) && ctl.pend_from_start);

    if (ctl.pend_cnt != 2'd0) begin
      if (cont) begin
        fresh = 1'b0;
        if (complete) begin
          flush_cnt               = keep ? ctl.pend_cnt : 2'd0;
          emit_b                  = keep;
          ctl_nxt.pend_cnt        = 2'd0;
          ctl_nxt.exp_len         = SEQ_LEN_INVALID;
          ctl_nxt.pend_from_start = 1'b0;
        end else begin
          if (ctl.pend_cnt != 2'd3) begin
            pend_nxt[ctl.pend_cnt] = b;
          end
          ctl_nxt.pend_cnt = ctl.pend_cnt + 2'd1;
          if (item.stream_end) begin
            flush_cnt = ctl.pend_cnt;
            emit_b    = 1'b1;
          end
        end
      end else begin
        flush_cnt               = ctl.pend_cnt;
        ctl_nxt.pend_cnt        = 2'd0;
        ctl_nxt.exp_len         = SEQ_LEN_INVALID;
        ctl_nxt.pend_from_start = 1'b0;
      end
    end

    if (fresh) begin
      ctl_nxt.at_start = 1'b0;
      if (len <= SEQ_LEN_ONE || item.stream_end) begin
        emit_b = 1'b1;
      end else begin
        pend_nxt[0]             = b;
        ctl_nxt.pend_cnt        = 2'd1;
        ctl_nxt.exp_len         = len;
        ctl_nxt.pend_from_start = ctl.at_start;
      end
    end

    if (item.stream_end) begin
      ctl_nxt.pend_cnt        = 2'd0;
      ctl_nxt.exp_len         = SEQ_LEN_INVALID;
      ctl_nxt.pend_from_start = 1'b0;
      ctl_nxt.at_start        = 1'b1;
    end

    burst.data[0] = (flush_cnt > 2'd0) ? pend[0] : b;
    burst.data[1] = (flush_cnt > 2'd1) ? pend[1] : b;
    burst.data[2] = (flush_cnt > 2'd2) ? pend[2] : b;
    burst.data[3] = b;
    burst.cnt     = {1'b0, flush_cnt} + {2'b00, emit_b};
  end

endmodule
`default_nettype wire

@@ design/utf8_invisible_char_stripper.sv @@
// top level: input register, decode step and output burst register
// an accepted item's results are offered from the burst register, not combinationally
// throughput: one item per cycle while the burst register can take its results;
//   the single output port drains the burst one byte a cycle while out_ready is high
// reset: synchronous active low, clears control state and starts a new stream
`default_nettype none
module utf8_invisible_char_stripper
  import utf8s_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire in_item_t in_item,
  output logic      out_valid,
  input  wire       out_ready,
  output out_item_t out_item
);

  logic     in_valid_r;
  in_item_t in_item_r;
  ctl_t     ctl_r;
  ctl_t     ctl_nxt;
  pend_t    pend_r;
  pend_t    pend_nxt;
  burst_t   step_burst;
  logic [3:0][7:0] bdata_r;
  logic [2:0]      bcnt_r;
  logic     load_ok;
  logic     adv;
  logic     pop;

  utf8s_step u_step (
    .item     (in_item_r),
    .ctl      (ctl_r),
    .pend     (pend_r),
    .ctl_nxt  (ctl_nxt),
    .pend_nxt (pend_nxt),
    .burst    (step_burst)
  );

  assign out_valid            = (bcnt_r != 3'd0);
  assign out_item.out_byte    = bdata_r[0];
  assign out_item.last_of_run = (bcnt_r == 3'd1);
  assign pop                  = out_valid && out_ready;
  assign load_ok              = (bcnt_r == 3'd0) || ((bcnt_r == 3'd1) && out_ready);
  assign adv                  = in_valid_r && ((step_burst.cnt == 3'd0) || load_ok);
  assign in_ready             = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.pend_cnt        <= 2'd0;
      ctl_r.exp_len         <= SEQ_LEN_INVALID;
      ctl_r.at_start        <= 1'b1;
      ctl_r.pend_from_start <= 1'b0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 3'd0;
    end else if (adv && (step_burst.cnt != 3'd0)) begin
      bcnt_r <= step_burst.cnt;
    end else if (pop) begin
      bcnt_r <= bcnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (step_burst.cnt != 3'd0)) begin
      bdata_r <= step_burst.data;
    end else if (pop) begin
      bdata_r <= {8'd0, bdata_r[3:1]};
    end
  end

`ifndef SYNTH
  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= 3'd4)
    else $error("burst count above four");

  a_pend_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.pend_cnt != 2'd0) |-> (ctl_r.exp_len > {1'b0, ctl_r.pend_cnt}))
    else $error("pending bytes not below sequence length");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.pend_cnt == 2'd0) |-> ((ctl_r.exp_len == SEQ_LEN_INVALID) &&
                                  !ctl_r.pend_from_start))
    else $error("stale sequence state with nothing pending");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_item_r.stream_end) |=> (ctl_r.at_start && (ctl_r.pend_cnt == 2'd0)))
    else $error("stream end did not restart the stream");
`endif

endmodule
`default_nettype wire
